/* hdl/las_pkg.sv */
// ----------------------------------------------------------------------------
// las_pkg
// Shared types and constants of the local alignment scorer.
// ----------------------------------------------------------------------------
package las_pkg;

  localparam int QUERY_CELLS = 256;
  localparam int COL_W       = 16;
  localparam int SYM_W       = 8;
  localparam int SCORE_W     = 12;
  localparam int CALC_W      = SCORE_W + 2;
  localparam int ROW_W       = $clog2(QUERY_CELLS + 1);
  localparam int CNT_W       = $clog2(QUERY_CELLS + 1);
  localparam int MATCH_W     = 4;
  localparam int CFG_W       = 5;
  localparam int CFG_IDX_W   = 2;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
  localparam logic [COL_W-1:0]   COL_MAX   = {COL_W{1'b1}};

  // command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_TARGET = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 2'd2;

  localparam logic [MATCH_W-1:0] MATCH_RST    = 4'd3;
  localparam logic [CFG_W-1:0]   MISMATCH_RST = 5'b11101;
  localparam logic [CFG_W-1:0]   GAP_RST      = 5'b11110;

  typedef struct packed {
    logic [MATCH_W-1:0] match;
    logic [CFG_W-1:0]   mismatch;
    logic [CFG_W-1:0]   gap;
  } cfg_t;

  // one target symbol travelling down the chain
  typedef struct packed {
    logic               last;
    logic [SYM_W-1:0]   symbol;
    logic [COL_W-1:0]   col;
    logic [SCORE_W-1:0] up;
    logic [SCORE_W-1:0] diag;
    logic [SCORE_W-1:0] best_score;
    logic [ROW_W-1:0]   best_row;
    logic [COL_W-1:0]   best_col;
  } wave_t;

  typedef struct packed {
    logic             en;
    logic             clear;
    logic             load;
    logic [ROW_W-1:0] wr_row;
    logic [SYM_W-1:0] sym;
    logic [ROW_W-1:0] qlen;
  } cell_ctl_t;

endpackage

/* hdl/las_in_if.sv */
// ----------------------------------------------------------------------------
// las_in_if
// Input channel: query loads and target symbols.
// ----------------------------------------------------------------------------
interface las_in_if;
  import las_pkg::*;

  logic             valid;
  logic             ready;
  logic             command;
  logic [SYM_W-1:0] symbol;
  logic             last;

  modport source (output valid, output command, output symbol, output last, input ready);
  modport sink   (input valid, input command, input symbol, input last, output ready);

endinterface

/* hdl/las_out_if.sv */
// ----------------------------------------------------------------------------
// las_out_if
// Result channel: best score and its position.
// ----------------------------------------------------------------------------
interface las_out_if;
  import las_pkg::*;

  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] best_score;
  logic [ROW_W-1:0]   best_row;
  logic [COL_W-1:0]   best_col;

  modport source (output valid, output best_score, output best_row, output best_col,
                  input ready);
  modport sink   (input valid, input best_score, input best_row, input best_col,
                  output ready);

endinterface

/* hdl/las_cell.sv */
// ----------------------------------------------------------------------------
// las_cell
// One query row of the systolic score array.
// ----------------------------------------------------------------------------
module las_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  las_pkg::cell_ctl_t ctl,
  input  las_pkg::cfg_t      cfg,
  input  logic [las_pkg::ROW_W-1:0] row,
  input  logic               in_vld,
  input  las_pkg::wave_t     in_wave,
  output logic               out_vld,
  output las_pkg::wave_t     out_wave
);
  import las_pkg::*;

  logic [SYM_W-1:0]   qsym_r;
  logic [SCORE_W-1:0] h_r;
  logic [SCORE_W-1:0] h_nxt;
  logic [SCORE_W-1:0] lb_score_r;
  logic [SCORE_W-1:0] lb_score_nxt;
  logic [COL_W-1:0]   lb_col_r;
  logic [COL_W-1:0]   lb_col_nxt;
  logic               vld_r;
  wave_t              wave_r;
  wave_t              wave_nxt;

  logic                     act;
  logic signed [CALC_W-1:0] sub;
  logic signed [CALC_W-1:0] gap_ext;
  logic signed [CALC_W-1:0] diag_sum;
  logic signed [CALC_W-1:0] up_sum;
  logic signed [CALC_W-1:0] left_sum;
  logic signed [CALC_W-1:0] v_max;
  logic [SCORE_W-1:0]       v;

  always_comb begin
    // rows past the loaded query stay at zero
    act = (row <= ctl.qlen);
    if (qsym_r == in_wave.symbol) begin
      sub = $signed({{(CALC_W-MATCH_W){1'b0}}, cfg.match});
    end else begin
      sub = $signed({{(CALC_W-CFG_W){cfg.mismatch[CFG_W-1]}}, cfg.mismatch});
    end
    gap_ext  = $signed({{(CALC_W-CFG_W){cfg.gap[CFG_W-1]}}, cfg.gap});
    diag_sum = $signed({2'b00, in_wave.diag}) + sub;
    up_sum   = $signed({2'b00, in_wave.up}) + gap_ext;
    left_sum = $signed({2'b00, h_r}) + gap_ext;

    v_max = diag_sum;
    if (up_sum > v_max) begin
      v_max = up_sum;
    end
    if (left_sum > v_max) begin
      v_max = left_sum;
    end
    if (v_max < $signed(CALC_W'(0))) begin
      v = '0;
    end else if (v_max > $signed({2'b00, SCORE_MAX})) begin
      v = SCORE_MAX;
    end else begin
      v = v_max[SCORE_W-1:0];
    end
    h_nxt = act ? v : '0;

    // earliest column wins inside a row
    lb_score_nxt = lb_score_r;
    lb_col_nxt   = lb_col_r;
    if (act && (v > lb_score_r)) begin
      lb_score_nxt = v;
      lb_col_nxt   = in_wave.col;
    end

    wave_nxt      = in_wave;
    wave_nxt.up   = h_nxt;
    wave_nxt.diag = h_r;
    // lower rows already in the item win ties
    if (act && (lb_score_nxt > in_wave.best_score)) begin
      wave_nxt.best_score = lb_score_nxt;
      wave_nxt.best_row   = row;
      wave_nxt.best_col   = lb_col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= 1'b0;
      h_r        <= '0;
      lb_score_r <= '0;
      lb_col_r   <= '0;
    end else begin
      if (ctl.en) begin
        vld_r <= in_vld;
      end
      if (ctl.clear) begin
        h_r        <= '0;
        lb_score_r <= '0;
        lb_col_r   <= '0;
      end else if (ctl.en && in_vld) begin
        // the final symbol of a stream leaves the row clean for the next one
        h_r        <= in_wave.last ? '0 : h_nxt;
        lb_score_r <= in_wave.last ? '0 : lb_score_nxt;
        lb_col_r   <= in_wave.last ? '0 : lb_col_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en && in_vld) begin
      wave_r <= wave_nxt;
    end
    if (ctl.load && (ctl.wr_row == row)) begin
      qsym_r <= ctl.sym;
    end
  end

  assign out_vld  = vld_r;
  assign out_wave = wave_r;

endmodule

/* hdl/local_alignment_scorer_unit.sv */
// A result is registered on the output once its last target item leaves the last cell.
// Throughput: one target item per cycle while no result waits on the output; each
// item walks the chain of QUERY_CELLS cells. A query load item waits until no target
// item is left in the chain.
// Reset is synchronous: scores, best cells, query length and counters clear at once;
// the stored query symbols are not reset.
// ----------------------------------------------------------------------------
// local_alignment_scorer_unit
// Smith-Waterman local score with linear gap on a systolic row of cells.
// ----------------------------------------------------------------------------
module local_alignment_scorer_unit (
  input  logic      clk,
  input  logic      rst_n,
  las_in_if.sink    in_ch,
  las_out_if.source out_ch,
  input  logic                          cfg_we,
  input  logic [las_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [las_pkg::CFG_W-1:0]     cfg_wdata
);
  import las_pkg::*;

  cfg_t             cfg_r;
  logic [ROW_W-1:0] qlen_r;
  logic             qdone_r;
  logic [COL_W-1:0] col_r;
  logic [CNT_W-1:0] inflight_r;
  logic [CNT_W-1:0] inflight_nxt;

  logic               out_valid_r;
  logic [SCORE_W-1:0] out_score_r;
  logic [ROW_W-1:0]   out_row_r;
  logic [COL_W-1:0]   out_col_r;

  logic             en;
  logic             acc;
  logic             acc_load;
  logic             acc_tgt;
  logic             leave;
  logic [ROW_W-1:0] q_base;
  logic             q_room;
  logic [COL_W-1:0] col_inc;
  cell_ctl_t        ctl;
  wave_t            head_wave;

  logic  vld [0:QUERY_CELLS];
  wave_t wv  [0:QUERY_CELLS];

  // whole chain holds while a result waits on the output
  assign en       = !(out_valid_r && !out_ch.ready);
  assign in_ch.ready = en && ((in_ch.command == CMD_TARGET) || (inflight_r == '0));
  assign acc      = in_ch.valid && in_ch.ready;
  assign acc_load = acc && (in_ch.command == CMD_LOAD);
  assign acc_tgt  = acc && (in_ch.command == CMD_TARGET);
  assign leave    = en && vld[QUERY_CELLS];

  assign vld[0] = acc_tgt;
  assign wv[0]  = head_wave;

  always_comb begin
    q_base  = qdone_r ? '0 : qlen_r;
    q_room  = (q_base < ROW_W'(QUERY_CELLS));
    col_inc = (col_r == COL_MAX) ? col_r : col_r + 1'b1;

    ctl.en     = en;
    ctl.clear  = acc_load;
    ctl.load   = acc_load && q_room;
    ctl.wr_row = q_base + 1'b1;
    ctl.sym    = in_ch.symbol;
    ctl.qlen   = qlen_r;

    head_wave.last       = in_ch.last;
    head_wave.symbol     = in_ch.symbol;
    head_wave.col        = col_inc;
    head_wave.up         = '0;
    head_wave.diag       = '0;
    head_wave.best_score = '0;
    head_wave.best_row   = '0;
    head_wave.best_col   = '0;

    case ({acc_tgt, leave})
      2'b10:   inflight_nxt = inflight_r + 1'b1;
      2'b01:   inflight_nxt = inflight_r - 1'b1;
      default: inflight_nxt = inflight_r;
    endcase
  end

  for (genvar i = 0; i < QUERY_CELLS; i++) begin : g_cell
    las_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .cfg      (cfg_r),
      .row      (ROW_W'(i + 1)),
      .in_vld   (vld[i]),
      .in_wave  (wv[i]),
      .out_vld  (vld[i+1]),
      .out_wave (wv[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.match    <= MATCH_RST;
      cfg_r.mismatch <= MISMATCH_RST;
      cfg_r.gap      <= GAP_RST;
      qlen_r         <= '0;
      qdone_r        <= 1'b0;
      col_r          <= '0;
      inflight_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MATCH:    cfg_r.match    <= cfg_wdata[MATCH_W-1:0];
          CFG_MISMATCH: cfg_r.mismatch <= cfg_wdata;
          CFG_GAP:      cfg_r.gap      <= cfg_wdata;
          default:      ;
        endcase
      end
      if (acc_load) begin
        qlen_r  <= q_room ? q_base + 1'b1 : q_base;
        qdone_r <= in_ch.last;
        col_r   <= '0;
      end else if (acc_tgt) begin
        col_r <= in_ch.last ? '0 : col_inc;
      end
      inflight_r <= inflight_nxt;
      if (leave && wv[QUERY_CELLS].last) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (leave && wv[QUERY_CELLS].last) begin
      out_score_r <= wv[QUERY_CELLS].best_score;
      out_row_r   <= wv[QUERY_CELLS].best_row;
      out_col_r   <= wv[QUERY_CELLS].best_col;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.best_score = out_score_r;
  assign out_ch.best_row   = out_row_r;
  assign out_ch.best_col   = out_col_r;

`ifndef SYNTH
  a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
    acc_load |-> (inflight_r == '0))
    else $error("query load while target items are in the chain");

  a_inflight_max: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= CNT_W'(QUERY_CELLS))
    else $error("in-flight count exceeds chain length");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (leave && wv[QUERY_CELLS].last) |=> out_valid_r)
    else $error("result leaving the chain was not captured");

  a_qlen_max: assert property (@(posedge clk) disable iff (!rst_n)
    qlen_r <= ROW_W'(QUERY_CELLS))
    else $error("query length beyond cell count");

  a_chain_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("item accepted while the chain is held");
`endif

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Checks the local alignment scorer against a cycle-free score matrix model.
// Queries and target streams go in through a random-idling driver, and each
// best cell that comes out is compared field by field with the predicted one.
// ----------------------------------------------------------------------------
module tb_top;
  import las_pkg::*;

  localparam int LIMIT     = 4000000;
  localparam int LONG_HOLD = 800;
  localparam int SETTLE    = QUERY_CELLS + 16;

  typedef struct packed {
    logic             command;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } seq_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
  } best_cell_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  las_in_if  in_if ();
  las_out_if out_if ();

  local_alignment_scorer_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // score matrix model state
  logic [SYM_W-1:0] query_mem [QUERY_CELLS];
  int unsigned      q_len;
  bit               q_done;
  int               col_h [QUERY_CELLS+1];
  int unsigned      col_n;
  int               top_s;
  int unsigned      top_r;
  int unsigned      top_c;
  int               w_match;
  int               w_mismatch;
  int               w_gap;

  seq_item_t  pending_items [$];
  best_cell_t best_cells_due [$];
  seq_item_t  offered;
  best_cell_t want;

  int  pushed;
  int  mismatches;
  int  cycles;
  int  gap_left;
  int  stall_left;
  bit  calm;
  bit  hold_arm;
  bit  hold_used;
  logic [SYM_W-1:0] alpha [4];

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("** local_alignment_scorer_unit: FAILED **");
      $finish;
    end
  end

  function automatic void clear_scan();
    for (int i = 0; i <= QUERY_CELLS; i++) col_h[i] = 0;
    col_n = 0;
    top_s = 0;
    top_r = 0;
    top_c = 0;
  endfunction

  // one item through the model; a closing target item yields the best cell
  function automatic void score_item(input seq_item_t it);
    int diag;
    int up;
    int left;
    int v;
    best_cell_t bc;
    if (it.command == CMD_LOAD) begin
      if (q_done) begin
        q_len = 0;
        q_done = 0;
      end
      clear_scan();
      if (q_len < QUERY_CELLS) begin
        query_mem[q_len] = it.symbol;
        q_len++;
      end
      if (it.last) q_done = 1;
    end else begin
      if (col_n < COL_MAX) col_n++;
      diag = 0;
      up = 0;
      for (int unsigned i = 1; i <= q_len; i++) begin
        left = col_h[i];
        v = diag + ((query_mem[i-1] == it.symbol) ? w_match : w_mismatch);
        if (up + w_gap > v) v = up + w_gap;
        if (left + w_gap > v) v = left + w_gap;
        if (v < 0) v = 0;
        if (v > int'(SCORE_MAX)) v = int'(SCORE_MAX);
        diag = left;
        col_h[i] = v;
        up = v;
        // equal score still wins when it sits in an earlier row
        if (v > top_s || (v > 0 && v == top_s && i < top_r)) begin
          top_s = v;
          top_r = i;
          top_c = col_n;
        end
      end
      if (it.last) begin
        bc.score = top_s[SCORE_W-1:0];
        bc.row   = top_r[ROW_W-1:0];
        bc.col   = top_c[COL_W-1:0];
        best_cells_due.push_back(bc);
        clear_scan();
      end
    end
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int expected);
    mismatches++;
    $display("mismatch at cycle %0d: %s got %0d, expected %0d", cycles, what, got,
             expected);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) score_item(offered);
      if (!(in_if.valid && !in_if.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
          gap_left = $urandom_range(0, 10);
          in_if.valid <= 1'b0;
        end else begin
          offered = pending_items.pop_front();
          in_if.valid   <= 1'b1;
          in_if.command <= offered.command;
          in_if.symbol  <= offered.symbol;
          in_if.last    <= offered.last;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (best_cells_due.size() == 0) begin
          flag_mismatch("result with nothing due, best_score", out_if.best_score, -1);
        end else begin
          want = best_cells_due.pop_front();
          if (out_if.best_score !== want.score)
            flag_mismatch("best_score", out_if.best_score, want.score);
          if (out_if.best_row !== want.row)
            flag_mismatch("best_row", out_if.best_row, want.row);
          if (out_if.best_col !== want.col)
            flag_mismatch("best_col", out_if.best_col, want.col);
        end
      end
      if (hold_arm && !hold_used) begin
        hold_used = 1;
        stall_left = LONG_HOLD;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic push_item(input logic cmd, input logic [SYM_W-1:0] sym, input logic lst);
    seq_item_t it;
    it.command = cmd;
    it.symbol  = sym;
    it.last    = lst;
    pending_items.push_back(it);
    pushed++;
  endtask

  task automatic new_alphabet();
    for (int k = 0; k < 4; k++) alpha[k] = SYM_W'($urandom_range(0, 255));
  endtask

  // mostly from a small alphabet so that matches are common
  function automatic logic [SYM_W-1:0] pick_sym();
    if ($urandom_range(0, 7) == 0) return SYM_W'($urandom_range(0, 255));
    return alpha[$urandom_range(0, 3)];
  endfunction

  task automatic load_query(input int n, input bit close);
    for (int k = 0; k < n; k++) push_item(CMD_LOAD, pick_sym(), close && k == n - 1);
  endtask

  task automatic stream_target(input int n, input bit close);
    for (int k = 0; k < n; k++) push_item(CMD_TARGET, pick_sym(), close && k == n - 1);
  endtask

  // wait for all items in, all results out, then for the chain to empty
  task automatic drain();
    while (pending_items.size() != 0 || in_if.valid || best_cells_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MATCH:    w_match = int'(val[MATCH_W-1:0]);
      CFG_MISMATCH: w_mismatch = int'($signed(val));
      CFG_GAP:      w_gap = int'($signed(val));
      default: ;
    endcase
  endtask

  task automatic set_scoring(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] mm,
                             input logic [CFG_W-1:0] g);
    write_reg(CFG_MATCH, m);
    write_reg(CFG_MISMATCH, mm);
    write_reg(CFG_GAP, g);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_burst(input int n, input bit full_patterns);
    int stop;
    int kind;
    stop = pushed + n;
    while (pushed < stop) begin
      kind = $urandom_range(0, 15);
      if (kind == 0) begin
        repeat ($urandom_range(1, 6))
          push_item($urandom_range(0, 1) ? CMD_TARGET : CMD_LOAD,
                    SYM_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (kind == 1) begin
        // targets against a query still open, then the query grows
        new_alphabet();
        load_query($urandom_range(1, 6), 1'b0);
        stream_target($urandom_range(1, 8), 1'($urandom_range(0, 1)));
        load_query($urandom_range(1, 4), 1'b1);
        stream_target($urandom_range(1, 10), 1'b1);
      end else begin
        new_alphabet();
        load_query(($urandom_range(0, 7) == 0) ? $urandom_range(13, 48)
                                               : $urandom_range(1, 12), 1'b1);
        repeat ($urandom_range(1, 4))
          stream_target(($urandom_range(0, 9) == 0) ? $urandom_range(17, 60)
                                                    : $urandom_range(1, 16),
                        $urandom_range(0, 7) != 0);
      end
    end
    if (full_patterns) set_scoring(CFG_W'($urandom_range(0, 31)),
                                   CFG_W'($urandom_range(0, 31)),
                                   CFG_W'($urandom_range(0, 31)));
  endtask

  initial begin
    logic [SYM_W-1:0] ovf_syms [260];
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MATCH;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.command = CMD_LOAD;
    in_if.symbol = '0;
    in_if.last = 1'b0;
    out_if.ready = 1'b0;
    cycles = 0;
    pushed = 0;
    mismatches = 0;
    calm = 0;
    hold_arm = 0;
    hold_used = 0;
    q_len = 0;
    q_done = 0;
    clear_scan();
    w_match = int'(MATCH_RST);
    w_mismatch = int'($signed(MISMATCH_RST));
    w_gap = int'($signed(GAP_RST));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty query straight after reset
    push_item(CMD_TARGET, 8'h58, 1'b0);
    push_item(CMD_TARGET, 8'h41, 1'b1);
    // tie: equal score in an earlier row replaces the best cell
    push_item(CMD_LOAD, 8'h41, 1'b0);
    push_item(CMD_LOAD, 8'h42, 1'b1);
    push_item(CMD_TARGET, 8'h42, 1'b0);
    push_item(CMD_TARGET, 8'h41, 1'b1);
    // target before the query is closed, then the query grows
    push_item(CMD_LOAD, 8'h43, 1'b0);
    push_item(CMD_TARGET, 8'h43, 1'b1);
    push_item(CMD_LOAD, 8'h44, 1'b1);
    push_item(CMD_TARGET, 8'h43, 1'b0);
    push_item(CMD_TARGET, 8'h44, 1'b1);
    // load in the middle of a stream starts a new query
    push_item(CMD_TARGET, 8'h43, 1'b0);
    push_item(CMD_LOAD, 8'h45, 1'b1);
    push_item(CMD_TARGET, 8'h45, 1'b1);
    // symbol extremes
    push_item(CMD_LOAD, 8'h00, 1'b0);
    push_item(CMD_LOAD, 8'hff, 1'b1);
    push_item(CMD_TARGET, 8'hff, 1'b0);
    push_item(CMD_TARGET, 8'h00, 1'b0);
    push_item(CMD_TARGET, 8'hff, 1'b1);
    drain();

    // query longer than the store: the tail is dropped, and positive mismatch
    // and gap drive scores into saturation
    set_scoring(5'd15, 5'd15, 5'd15);
    new_alphabet();
    for (int k = 0; k < 260; k++) begin
      ovf_syms[k] = SYM_W'($urandom_range(0, 255));
      push_item(CMD_LOAD, ovf_syms[k], k == 259);
    end
    for (int k = 230; k < 260; k++) push_item(CMD_TARGET, ovf_syms[k], k == 259);
    stream_target(3, 1'b1);
    drain();

    set_scoring(5'd0, 5'd0, 5'd0);
    new_alphabet();
    load_query(4, 1'b1);
    stream_target(6, 1'b1);
    drain();

    set_scoring({1'b0, 4'd15}, 5'b10000, 5'b10000);
    random_burst(120, 1'b0);
    hold_arm = 1;
    drain();

    set_scoring(CFG_W'($urandom_range(0, 31)), CFG_W'($urandom_range(0, 31)),
                CFG_W'($urandom_range(0, 31)));
    random_burst(120, 1'b0);
    drain();

    set_scoring(CFG_W'($urandom_range(0, 15)), CFG_W'($urandom_range(16, 32) % 32),
                CFG_W'($urandom_range(16, 32) % 32));
    random_burst(120, 1'b0);
    drain();

    calm = 1;
    set_scoring({1'b0, MATCH_RST}, MISMATCH_RST, GAP_RST);
    random_burst(70, 1'b0);
    drain();

    if (mismatches == 0) begin
      $display("** local_alignment_scorer_unit: PASSED **");
    end else begin
      $display("** local_alignment_scorer_unit: FAILED **");
    end
    $finish;
  end

endmodule
